@@ design/bst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the byte stream tokenizer: transaction
// structs, token type codes and the fixed keyword list.
// ----------------------------------------------------------------------------
package bst_pkg;

   // Token type codes
   localparam logic [2:0] TOK_IDENT   = 3'd0;
   localparam logic [2:0] TOK_KEYWORD = 3'd1;
   localparam logic [2:0] TOK_NUMBER  = 3'd2;
   localparam logic [2:0] TOK_FLOAT   = 3'd3;
   localparam logic [2:0] TOK_OPER    = 3'd4;
   localparam logic [2:0] TOK_EOF     = 3'd5;

   // Byte codes the scanner looks at
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;

   localparam int KW_COUNT = 10;

   // Results one input transaction can cause: closed token, operator or
   // token closed at end of source, end of file
   localparam int SLOT_COUNT = 3;

   // Input transaction
   typedef struct packed {
      logic [7:0] source_byte;
      logic       byte_valid;
      logic       end_of_source;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0]  token_type;
      logic [3:0]  keyword_index;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [15:0] token_length;
      logic [7:0]  operator_byte;
      logic        last_of_run;
   } rsp_type;

   // All results of one input transaction, in delivery order
   typedef struct packed {
      logic [SLOT_COUNT-1:0]          valid;
      rsp_type [SLOT_COUNT-1:0]       slot;
   } bundle_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } kw_hit_type;

   // Keyword text, first character in the most significant byte used
   function automatic logic [63:0] kw_word(input logic [3:0] k);
      logic [63:0] w;
      unique case (k)
         4'd0:    w = 64'h6966;               // if
         4'd1:    w = 64'h656C_7365;          // else
         4'd2:    w = 64'h77_6869_6C65;       // while
         4'd3:    w = 64'h7265_7475_726E;     // return
         4'd4:    w = 64'h666E;               // fn
         4'd5:    w = 64'h6C_6574;            // let
         4'd6:    w = 64'h63_6F6E_7374;       // const
         4'd7:    w = 64'h6576_616C;          // eval
         4'd8:    w = 64'h4447;               // DG
         4'd9:    w = 64'h43_6170_7375_6C65;  // Capsule
         default: w = 64'h0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      logic [3:0] n;
      unique case (k)
         4'd0:    n = 4'd2;
         4'd1:    n = 4'd4;
         4'd2:    n = 4'd5;
         4'd3:    n = 4'd6;
         4'd4:    n = 4'd2;
         4'd5:    n = 4'd3;
         4'd6:    n = 4'd5;
         4'd7:    n = 4'd4;
         4'd8:    n = 4'd2;
         4'd9:    n = 4'd7;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

@@ design/bst_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_scan
// Scanner state and the single-pass logic that turns one input transaction
// into up to three results and the next scanner state.
// ----------------------------------------------------------------------------
module bst_scan #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  bst_pkg::req_type    item,
   output bst_pkg::bundle_type bundle
);
   import bst_pkg::*;

   localparam int WIN_BITS = 8 * KEYWORD_CHARS;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUMBER} mode_type;

   mode_type                 mode_ff, mode_in;
   logic                     dot_ff, dot_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] tline_ff, tline_in;
   logic [POSITION_BITS-1:0] tcol_ff, tcol_in;
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic [WIN_BITS-1:0]      window_ff, window_in;

   logic [7:0] b;
   logic       is_letter, is_digit, is_dot, is_space, grow, extend_ok;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   // Ten parallel compares of the word window against the keyword list
   function automatic kw_hit_type kw_match(input logic [WIN_BITS-1:0]      w,
                                           input logic [POSITION_BITS-1:0] n);
      kw_hit_type r;
      r = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!r.hit && n == POSITION_BITS'(kw_len(4'(k)))
             && w == WIN_BITS'(kw_word(4'(k)))) begin
            r.hit   = 1'b1;
            r.index = 4'(k);
         end
      end
      return r;
   endfunction

   function automatic rsp_type make_token(input mode_type                 m,
                                          input logic                     d,
                                          input kw_hit_type               kw,
                                          input logic [POSITION_BITS-1:0] ln,
                                          input logic [POSITION_BITS-1:0] cl,
                                          input logic [POSITION_BITS-1:0] n);
      rsp_type r;
      r = '0;
      if (m == MODE_IDENT) begin
         r.token_type    = kw.hit ? TOK_KEYWORD : TOK_IDENT;
         r.keyword_index = kw.hit ? kw.index : 4'd0;
      end else begin
         r.token_type    = d ? TOK_FLOAT : TOK_NUMBER;
      end
      r.start_line   = 16'(ln);
      r.start_column = 16'(cl);
      r.token_length = 16'(n);
      return r;
   endfunction

   // Byte classes
   assign b         = item.source_byte;
   assign is_letter = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
                      || b == CHAR_UNDERSCORE;
   assign is_digit  = b >= 8'h30 && b <= 8'h39;
   assign is_dot    = b == CHAR_DOT;
   assign is_space  = b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   assign extend_ok = (mode_ff == MODE_IDENT && (is_letter || is_digit))
                      || (mode_ff == MODE_NUMBER && (is_digit || is_dot));

   // Next state and results for the transaction at the scanner input
   always_comb begin
      mode_in   = mode_ff;
      dot_in    = dot_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      count_in  = count_ff;
      window_in = window_ff;
      bundle    = '0;
      grow      = 1'b0;

      if (item.byte_valid) begin
         if (extend_ok) begin
            grow = 1'b1;
         end else begin
            // close whatever token is open
            if (mode_ff != MODE_IDLE) begin
               bundle.valid[0] = 1'b1;
               bundle.slot[0]  = make_token(mode_ff, dot_ff, kw_match(window_ff, count_ff),
                                            tline_ff, tcol_ff, count_ff);
            end
            mode_in   = MODE_IDLE;
            dot_in    = 1'b0;
            count_in  = '0;
            window_in = '0;
            priority if (is_space) begin
               if (b == CHAR_NEWLINE) begin
                  line_in = sat_inc(line_ff);
                  col_in  = POS_ONE;
               end else begin
                  col_in  = sat_inc(col_ff);
               end
            end else if (is_letter || is_digit) begin
               mode_in  = is_letter ? MODE_IDENT : MODE_NUMBER;
               tline_in = line_ff;
               tcol_in  = col_ff;
               grow     = 1'b1;
            end else begin
               bundle.valid[1]              = 1'b1;
               bundle.slot[1].token_type    = TOK_OPER;
               bundle.slot[1].start_line    = 16'(line_ff);
               bundle.slot[1].start_column  = 16'(col_ff);
               bundle.slot[1].token_length  = 16'd1;
               bundle.slot[1].operator_byte = b;
               col_in = sat_inc(col_ff);
            end
         end
      end

      // append the byte to the open token
      if (grow) begin
         count_in  = sat_inc(count_in);
         window_in = {window_in[WIN_BITS-9:0], b};
         if (is_dot) begin
            dot_in = 1'b1;
         end
         col_in = sat_inc(col_in);
      end

      // end of source: flush, end of file, back to reset state
      if (item.end_of_source) begin
         if (mode_in != MODE_IDLE) begin
            bundle.valid[1] = 1'b1;
            bundle.slot[1]  = make_token(mode_in, dot_in, kw_match(window_in, count_in),
                                         tline_in, tcol_in, count_in);
         end
         bundle.valid[2]             = 1'b1;
         bundle.slot[2].token_type   = TOK_EOF;
         bundle.slot[2].start_line   = 16'(line_in);
         bundle.slot[2].start_column = 16'(col_in);
         mode_in   = MODE_IDLE;
         dot_in    = 1'b0;
         line_in   = POS_ONE;
         col_in    = POS_ONE;
         tline_in  = POS_ONE;
         tcol_in   = POS_ONE;
         count_in  = '0;
         window_in = '0;
      end

      // flag the final result of this transaction
      priority if (bundle.valid[2]) begin
         bundle.slot[2].last_of_run = 1'b1;
      end else if (bundle.valid[1]) begin
         bundle.slot[1].last_of_run = 1'b1;
      end else if (bundle.valid[0]) begin
         bundle.slot[0].last_of_run = 1'b1;
      end
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         dot_ff    <= 1'b0;
         line_ff   <= POS_ONE;
         col_ff    <= POS_ONE;
         tline_ff  <= POS_ONE;
         tcol_ff   <= POS_ONE;
         count_ff  <= '0;
         window_ff <= '0;
      end else if (take) begin
         mode_ff   <= mode_in;
         dot_ff    <= dot_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         count_ff  <= count_in;
         window_ff <= window_in;
      end
   end

endmodule

@@ design/bst_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_out
// Result register: holds the results of one input transaction and hands
// them out one per cycle, in order, while rsp_stall is low.
// ----------------------------------------------------------------------------
module bst_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bst_pkg::bundle_type bundle,
   output logic                load_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bst_pkg::rsp_type    rsp_data
);
   import bst_pkg::*;

   logic [SLOT_COUNT-1:0]    pend_ff, pend_in, pend_left;
   rsp_type [SLOT_COUNT-1:0] slot_ff;
   logic                     fire;

   assign rsp_valid = |pend_ff;
   assign fire      = rsp_valid && !rsp_stall;
   // drop the lowest pending result once it is taken
   assign pend_left = fire ? (pend_ff & (pend_ff - SLOT_COUNT'(1))) : pend_ff;
   assign load_ok   = pend_left == '0;
   assign pend_in   = load ? bundle.valid : pend_left;

   // Lowest pending result goes out first
   always_comb begin
      priority if (pend_ff[0]) begin
         rsp_data = slot_ff[0];
      end else if (pend_ff[1]) begin
         rsp_data = slot_ff[1];
      end else begin
         rsp_data = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end
   end

endmodule

@@ design/byte_stream_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_tokenizer
// Streaming lexical scanner: one source byte per input transaction, tokens
// with type, start line, start column and length on the result channel.
//
// Input channel (req_): one byte, a byte-present flag and an end-of-source
// flag. Result channel (rsp_): one token per transaction; last_of_run marks
// the final token that an input transaction caused. An end-of-source
// transaction flushes the open token, gives an end of file token and
// returns the scanner to its reset state for the next source.
// A token is offered on rsp_ once the input transaction that closes it has
// passed the input register and then the result register.
// Throughput: one input transaction per cycle while rsp_stall is low and each
// causes at most one token; a transaction with several tokens holds the result
// register until all are taken, since the result channel moves one token per cycle.
// Reset (synchronous): line and column at 1, no token open, both registers
// empty. While rsp_stall is high the current token holds; one further input
// transaction is taken into the input register, then req_stall rises.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bst_pkg::rsp_type rsp_data
);
   import bst_pkg::*;

   logic       in_full_ff, in_full_in;
   req_type    in_data_ff;
   logic       req_fire, scan_take, load_ok;
   bundle_type bundle;

   // Input register
   assign scan_take  = in_full_ff && load_ok;
   assign req_stall  = in_full_ff && !scan_take;
   assign req_fire   = req_valid && !req_stall;
   assign in_full_in = req_fire || (in_full_ff && !scan_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff <= 1'b0;
      end else begin
         in_full_ff <= in_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   bst_scan #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .take   (scan_take),
      .item   (in_data_ff),
      .bundle (bundle)
   );

   bst_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (scan_take),
      .bundle    (bundle),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // End of file always closes the run and carries no length
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_type == TOK_EOF
      |-> rsp_data.last_of_run && rsp_data.token_length == 16'd0)
      else $error("end of file token not last or has a length");

   // Operators are exactly one byte long
   a_oper_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_type == TOK_OPER |-> rsp_data.token_length == 16'd1)
      else $error("operator token length is not one");

   // Only keywords carry a keyword index, only operators an operator byte
   a_kw_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_type != TOK_KEYWORD && rsp_data.token_type != TOK_OPER
      |-> rsp_data.keyword_index == 4'd0 && rsp_data.operator_byte == 8'd0)
      else $error("stray keyword index or operator byte");

   // A transaction handed to the scanner frees the input register
   a_in_drain: assert property (@(posedge clock) disable iff (reset)
      scan_take && !req_fire |=> !in_full_ff)
      else $error("input register did not drain");
`endif

endmodule
